// ----- src/cks_pkg.sv -----
`timescale 1ns / 1ps
// cks_pkg: shared constants, register indexes and lane mapping for the ChaCha20 keystream block.
// No dependencies.
package cks_pkg;

   localparam int WORD_BITS = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int KEY_WORDS = 8;
   localparam int NONCE_WORDS = 3;
   localparam int LANES = 4;
   localparam int ROUND_COUNT_DEFAULT = 20;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_0_1   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_2_3   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_4_5   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_6_7   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONCE_0_1 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONCE_2   = 3'd5;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

   // state position of a quarter-round operand: role 0..3 is a, b, c, d
   function automatic logic [3:0] lane_word(input logic [1:0] lane, input logic [1:0] role,
                                            input logic diag);
      logic [1:0] col;
      col = diag ? 2'(lane + role) : lane;
      return {role, col};
   endfunction

endpackage

// ----- src/cks_quarter_half.sv -----
`timescale 1ns / 1ps
// cks_quarter_half: one half of a ChaCha quarter-round (two add-xor-rotate steps) on one lane.
// Depends on cks_pkg.
module cks_quarter_half (
   input  logic              second_half,
   input  cks_pkg::word_type a_in,
   input  cks_pkg::word_type b_in,
   input  cks_pkg::word_type c_in,
   input  cks_pkg::word_type d_in,
   output cks_pkg::word_type a_out,
   output cks_pkg::word_type b_out,
   output cks_pkg::word_type c_out,
   output cks_pkg::word_type d_out
);

   cks_pkg::word_type a_sum;
   cks_pkg::word_type d_mix;
   cks_pkg::word_type d_rot;
   cks_pkg::word_type c_sum;
   cks_pkg::word_type b_mix;
   cks_pkg::word_type b_rot;

   always_comb begin
      a_sum = a_in + b_in;
      d_mix = d_in ^ a_sum;
      d_rot = second_half ? {d_mix[23:0], d_mix[31:24]} : {d_mix[15:0], d_mix[31:16]};
      c_sum = c_in + d_rot;
      b_mix = b_in ^ c_sum;
      b_rot = second_half ? {b_mix[24:0], b_mix[31:25]} : {b_mix[19:0], b_mix[31:20]};
   end

   assign a_out = a_sum;
   assign b_out = b_rot;
   assign c_out = c_sum;
   assign d_out = d_rot;

endmodule

// ----- src/chacha20_keystream_block_top.sv -----
`timescale 1ns / 1ps
// ChaCha20 keystream block top: config registers, round sequencer, output stage.
// Depends on cks_pkg and cks_quarter_half.
// Sequence: accept loads the initial state, then ceil(ROUND_COUNT/2) double rounds run, each as four
// half quarter-round passes of four lanes; then the sixteen output words are registered in order.
// start is accepted only while idle, so one block completes before the next one is taken.
// busy is high from the accepting edge until the last word is registered; results cannot stall.
// Synchronous active-high reset clears control state and all config registers to zero.
module chacha20_keystream_block_top #(
   parameter int ROUND_COUNT = cks_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [31:0]                         req_block_counter,
   output logic                                rsp_valid,
   output logic [31:0]                         rsp_keystream_word,
   output logic [3:0]                          rsp_word_index,
   output logic                                rsp_last_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cks_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cks_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
   localparam int DR_BITS = $clog2(DOUBLE_ROUNDS + 1);
   localparam logic [DR_BITS-1:0] DR_LAST = DR_BITS'(DOUBLE_ROUNDS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [DR_BITS-1:0] dr_ff, dr_in;
   logic [3:0]         emit_ff, emit_in;
   logic [31:0]        held_ff, held_in;

   cks_pkg::word_type key_ff [cks_pkg::KEY_WORDS];
   cks_pkg::word_type nonce_ff [cks_pkg::NONCE_WORDS];
   cks_pkg::word_type work_ff [cks_pkg::BLOCK_WORDS];
   cks_pkg::word_type work_in [cks_pkg::BLOCK_WORDS];
   cks_pkg::word_type init_words [cks_pkg::BLOCK_WORDS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic accept;
   logic diag;
   logic csr_write;

   cks_pkg::word_type qa [cks_pkg::LANES];
   cks_pkg::word_type qb [cks_pkg::LANES];
   cks_pkg::word_type qc [cks_pkg::LANES];
   cks_pkg::word_type qd [cks_pkg::LANES];
   cks_pkg::word_type ra [cks_pkg::LANES];
   cks_pkg::word_type rb [cks_pkg::LANES];
   cks_pkg::word_type rc [cks_pkg::LANES];
   cks_pkg::word_type rd [cks_pkg::LANES];

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign diag      = step_ff[1];
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      for (int i = 0; i < 4; i++) init_words[i] = cks_pkg::SIGMA[i];
      for (int i = 0; i < cks_pkg::KEY_WORDS; i++) init_words[4 + i] = key_ff[i];
      init_words[12] = held_ff;
      for (int i = 0; i < cks_pkg::NONCE_WORDS; i++) init_words[13 + i] = nonce_ff[i];
   end

   for (genvar l = 0; l < cks_pkg::LANES; l++) begin : g_lane
      assign qa[l] = work_ff[cks_pkg::lane_word(2'(l), 2'd0, diag)];
      assign qb[l] = work_ff[cks_pkg::lane_word(2'(l), 2'd1, diag)];
      assign qc[l] = work_ff[cks_pkg::lane_word(2'(l), 2'd2, diag)];
      assign qd[l] = work_ff[cks_pkg::lane_word(2'(l), 2'd3, diag)];

      cks_quarter_half u_qh (
         .second_half (step_ff[0]),
         .a_in        (qa[l]),
         .b_in        (qb[l]),
         .c_in        (qc[l]),
         .d_in        (qd[l]),
         .a_out       (ra[l]),
         .b_out       (rb[l]),
         .c_out       (rc[l]),
         .d_out       (rd[l])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dr_in        = dr_ff;
      emit_in      = emit_ff;
      held_in      = held_ff;
      work_in      = work_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = work_ff[emit_ff] + init_words[emit_ff];
      rsp_index_in = emit_ff;
      rsp_last_in  = (emit_ff == 4'hF);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               held_in = req_block_counter;
               work_in = init_words;
               work_in[12] = req_block_counter;
               step_in = 2'd0;
               dr_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int l = 0; l < cks_pkg::LANES; l++) begin
               work_in[cks_pkg::lane_word(2'(l), 2'd0, diag)] = ra[l];
               work_in[cks_pkg::lane_word(2'(l), 2'd1, diag)] = rb[l];
               work_in[cks_pkg::lane_word(2'(l), 2'd2, diag)] = rc[l];
               work_in[cks_pkg::lane_word(2'(l), 2'd3, diag)] = rd[l];
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               dr_in = dr_ff + 1'b1;
               if (dr_ff == DR_LAST) begin
                  emit_in = 4'd0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            emit_in = emit_ff + 4'd1;
            if (emit_ff == 4'hF) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         dr_ff        <= '0;
         emit_ff      <= 4'd0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dr_ff        <= dr_in;
         emit_ff      <= emit_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cks_pkg::KEY_WORDS; i++) key_ff[i] <= '0;
         for (int i = 0; i < cks_pkg::NONCE_WORDS; i++) nonce_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            cks_pkg::REG_KEY_0_1: begin
               key_ff[0] <= csr_data[31:0];
               key_ff[1] <= csr_data[63:32];
            end
            cks_pkg::REG_KEY_2_3: begin
               key_ff[2] <= csr_data[31:0];
               key_ff[3] <= csr_data[63:32];
            end
            cks_pkg::REG_KEY_4_5: begin
               key_ff[4] <= csr_data[31:0];
               key_ff[5] <= csr_data[63:32];
            end
            cks_pkg::REG_KEY_6_7: begin
               key_ff[6] <= csr_data[31:0];
               key_ff[7] <= csr_data[63:32];
            end
            cks_pkg::REG_NONCE_0_1: begin
               nonce_ff[0] <= csr_data[31:0];
               nonce_ff[1] <= csr_data[63:32];
            end
            cks_pkg::REG_NONCE_2: begin
               nonce_ff[2] <= csr_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_word = rsp_word_ff;
   assign rsp_word_index     = rsp_index_ff;
   assign rsp_last_word      = rsp_last_ff;

endmodule
